FILE: design/nla_pkg.sv
package nla_pkg;

    // requester ids, queue pointers and sockets
    localparam int ID_W           = 4;
    localparam int NUM_REQUESTERS = 2 ** ID_W;
    localparam int PTR_W          = ID_W + 1;
    localparam int SOCK_W         = 3;
    localparam int STATUS_W       = 2;

    // pointer value that marks an empty queue or the end of a chain
    localparam logic [PTR_W-1:0] NIL_ID = PTR_W'(NUM_REQUESTERS);

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_RELEASE = 2'd1,
        ST_DUPLICATE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINK,
        S_WALK,
        S_GRANT,
        S_FIXPREV,
        S_DONE
    } t_state;

    // how the successor fetched in S_GRANT is unlinked
    typedef enum logic [1:0] {
        M_SEC_ONLY,
        M_SEC_SPLICE,
        M_MAIN
    } t_mode;

endpackage

FILE: design/nla_req_if.sv
interface nla_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [nla_pkg::ID_W-1:0]    requester;
    logic [nla_pkg::SOCK_W-1:0]  socket;

    modport source (output valid, output command, output requester, output socket,
                    input ready);
    modport sink   (input valid, input command, input requester, input socket,
                    output ready);
endinterface

FILE: design/nla_rsp_if.sv
interface nla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          grant_valid;
    logic [nla_pkg::ID_W-1:0]      grant_id;
    logic [nla_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output grant_valid, output grant_id, output status,
                    input ready);
    modport sink   (input valid, input grant_valid, input grant_id, input status,
                    output ready);
endinterface

FILE: design/nla_cfg_if.sv
interface nla_cfg_if;
    logic valid;
    logic ready;
    logic local_first;

    modport source (output valid, output local_first, input ready);
    modport sink   (input valid, input local_first, output ready);
endinterface

FILE: design/nla_ram.sv
module nla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/numa_aware_lock_arbiter.sv
// Lock arbiter for 16 requesters spread over sockets, with socket-local handoff.
// i_in   : request beats (command 0 acquire, 1 release; requester id; socket).
// o_out  : one response beat per request: grant_valid, grant_id, status.
// i_cfg  : write of local_first (1 = hand the lock to a waiter on the holder's
//          socket first, 0 = plain FIFO handoff). Always ready.
// Timing: acquires, rejected commands and releases with nobody waiting answer
// in the cycle after acceptance. An acquire that queues also blocks the input
// while S_LINK writes the tail link. A release with waiters reads the link and
// socket RAMs through one registered read port: a local walk visits one waiter
// per cycle over up to 15 waiters; then, as needed, the successor is fetched
// (S_GRANT) or the moved run is fixed up (S_FIXPREV), and S_DONE loads the
// response. The walk over the waiter chain, one RAM read per cycle, sets the rate.
// One request is in flight at a time; i_in.ready is low while it is worked on.
// A finished response waits in the output register; a stalled o_out holds it,
// and no new request is taken until it can be replaced.
// Reset (synchronous, active low) frees the lock, empties both queues, clears
// all waiting flags and sets local_first to 1. The RAMs need no clearing.
module numa_aware_lock_arbiter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nla_req_if.sink    i_in,
    nla_rsp_if.source  o_out,
    nla_cfg_if.sink    i_cfg
);

    localparam int ID_W  = nla_pkg::ID_W;
    localparam int PTR_W = nla_pkg::PTR_W;
    localparam int SW    = nla_pkg::SOCK_W;
    localparam int NR    = nla_pkg::NUM_REQUESTERS;

    nla_pkg::t_state r_state, n_state;
    nla_pkg::t_mode  r_mode, n_mode;

    logic [PTR_W-1:0] r_cur, n_cur;
    logic [PTR_W-1:0] r_prev, n_prev;
    logic [ID_W-1:0]  r_req, n_req;
    logic             r_local_first;
    logic             r_lock_busy, n_lock_busy;
    logic [ID_W-1:0]  r_holder_id, n_holder_id;
    logic [SW-1:0]    r_holder_socket, n_holder_socket;
    logic [NR-1:0]    r_is_waiting, n_is_waiting;
    logic [PTR_W-1:0] r_main_head, n_main_head;
    logic [PTR_W-1:0] r_main_tail, n_main_tail;
    logic [PTR_W-1:0] r_second_head, n_second_head;
    logic [PTR_W-1:0] r_second_tail, n_second_tail;
    logic             r_res_gv, n_res_gv;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic             r_out_valid, n_out_valid;
    logic             r_out_gv, n_out_gv;
    logic [ID_W-1:0]  r_out_id, n_out_id;
    logic [nla_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    logic             in_acc;
    logic             out_free;
    logic             link_we;
    logic [ID_W-1:0]  link_waddr;
    logic [PTR_W-1:0] link_wdata;
    logic [PTR_W-1:0] link_rdata;
    logic             sock_we;
    logic [SW-1:0]    sock_rdata;
    logic [ID_W-1:0]  rd_addr;

    // handshakes
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == nla_pkg::S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.grant_valid = r_out_gv;
    assign o_out.grant_id    = r_out_id;
    assign o_out.status      = r_out_status;

    // the RAMs read the entry that r_cur will point at
    assign rd_addr = n_cur[ID_W-1:0];
    assign sock_we = in_acc && (i_in.command == nla_pkg::CMD_ACQUIRE) && r_lock_busy
                     && !r_is_waiting[i_in.requester] && (r_holder_id != i_in.requester);

    nla_ram #(.WIDTH(PTR_W), .DEPTH(NR)) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_waddr),
        .i_wr_data (link_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rdata)
    );

    nla_ram #(.WIDTH(SW), .DEPTH(NR)) u_sock_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sock_we),
        .i_wr_addr (i_in.requester),
        .i_wr_data (i_in.socket),
        .i_rd_addr (rd_addr),
        .o_rd_data (sock_rdata)
    );

    // next state, queue bookkeeping and RAM writes
    always_comb begin
        n_state         = r_state;
        n_mode          = r_mode;
        n_cur           = r_cur;
        n_prev          = r_prev;
        n_req           = r_req;
        n_lock_busy     = r_lock_busy;
        n_holder_id     = r_holder_id;
        n_holder_socket = r_holder_socket;
        n_is_waiting    = r_is_waiting;
        n_main_head     = r_main_head;
        n_main_tail     = r_main_tail;
        n_second_head   = r_second_head;
        n_second_tail   = r_second_tail;
        n_res_gv        = r_res_gv;
        n_res_id        = r_res_id;
        n_out_valid     = r_out_valid;
        n_out_gv        = r_out_gv;
        n_out_id        = r_out_id;
        n_out_status    = r_out_status;
        link_we         = 1'b0;
        link_waddr      = r_main_tail[ID_W-1:0];
        link_wdata      = nla_pkg::NIL_ID;

        // drop a response beat once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            nla_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_req        = i_in.requester;
                    n_out_valid  = 1'b1;
                    n_out_gv     = 1'b0;
                    n_out_id     = '0;
                    n_out_status = nla_pkg::ST_OK;
                    if (i_in.command == nla_pkg::CMD_ACQUIRE) begin
                        if (r_is_waiting[i_in.requester]
                            || (r_lock_busy && r_holder_id == i_in.requester)) begin
                            n_out_status = nla_pkg::ST_DUPLICATE;
                        end else if (!r_lock_busy) begin
                            n_lock_busy     = 1'b1;
                            n_holder_id     = i_in.requester;
                            n_holder_socket = i_in.socket;
                            n_out_gv        = 1'b1;
                            n_out_id        = i_in.requester;
                        end else begin
                            // new waiter: terminate its link, append next cycle
                            link_we    = 1'b1;
                            link_waddr = i_in.requester;
                            link_wdata = nla_pkg::NIL_ID;
                            n_is_waiting[i_in.requester] = 1'b1;
                            n_state    = nla_pkg::S_LINK;
                        end
                    end else begin
                        if (!r_lock_busy || r_holder_id != i_in.requester) begin
                            n_out_status = nla_pkg::ST_BAD_RELEASE;
                        end else if (r_main_head == nla_pkg::NIL_ID
                                     && r_second_head == nla_pkg::NIL_ID) begin
                            n_lock_busy = 1'b0;
                        end else begin
                            // response comes after the successor is found
                            n_out_valid = r_out_valid && !o_out.ready;
                            if (r_main_head == nla_pkg::NIL_ID) begin
                                n_cur   = r_second_head;
                                n_mode  = nla_pkg::M_SEC_ONLY;
                                n_state = nla_pkg::S_GRANT;
                            end else if (r_local_first) begin
                                n_cur   = r_main_head;
                                n_prev  = nla_pkg::NIL_ID;
                                n_state = nla_pkg::S_WALK;
                            end else if (r_second_head != nla_pkg::NIL_ID) begin
                                n_cur   = r_second_head;
                                n_mode  = nla_pkg::M_SEC_SPLICE;
                                n_state = nla_pkg::S_GRANT;
                            end else begin
                                n_cur   = r_main_head;
                                n_mode  = nla_pkg::M_MAIN;
                                n_state = nla_pkg::S_GRANT;
                            end
                        end
                    end
                end
            end

            nla_pkg::S_LINK: begin
                // append the new waiter to the main queue
                if (r_main_tail == nla_pkg::NIL_ID) begin
                    n_main_head = {1'b0, r_req};
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_main_tail[ID_W-1:0];
                    link_wdata = {1'b0, r_req};
                end
                n_main_tail = {1'b0, r_req};
                n_state     = nla_pkg::S_IDLE;
            end

            nla_pkg::S_WALK: begin
                if (sock_rdata == r_holder_socket) begin
                    // same-socket waiter found: grant it, move the skipped ones
                    n_holder_id     = r_cur[ID_W-1:0];
                    n_holder_socket = sock_rdata;
                    n_is_waiting[r_cur[ID_W-1:0]] = 1'b0;
                    n_res_gv        = 1'b1;
                    n_res_id        = r_cur[ID_W-1:0];
                    n_main_head     = link_rdata;
                    if (link_rdata == nla_pkg::NIL_ID) begin
                        n_main_tail = nla_pkg::NIL_ID;
                    end
                    if (r_prev != nla_pkg::NIL_ID) begin
                        if (r_second_head == nla_pkg::NIL_ID) begin
                            n_second_head = r_main_head;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = r_second_tail[ID_W-1:0];
                            link_wdata = r_main_head;
                        end
                        n_second_tail = r_prev;
                        n_state       = nla_pkg::S_FIXPREV;
                    end else begin
                        n_state = nla_pkg::S_DONE;
                    end
                end else if (link_rdata == nla_pkg::NIL_ID) begin
                    // no local waiter: fall back to queue order
                    if (r_second_head != nla_pkg::NIL_ID) begin
                        n_cur  = r_second_head;
                        n_mode = nla_pkg::M_SEC_SPLICE;
                    end else begin
                        n_cur  = r_main_head;
                        n_mode = nla_pkg::M_MAIN;
                    end
                    n_state = nla_pkg::S_GRANT;
                end else begin
                    // advance one waiter
                    n_prev = r_cur;
                    n_cur  = link_rdata;
                end
            end

            nla_pkg::S_GRANT: begin
                n_holder_id     = r_cur[ID_W-1:0];
                n_holder_socket = sock_rdata;
                n_is_waiting[r_cur[ID_W-1:0]] = 1'b0;
                n_res_gv        = 1'b1;
                n_res_id        = r_cur[ID_W-1:0];
                case (r_mode)
                    nla_pkg::M_SEC_ONLY: begin
                        n_main_head   = link_rdata;
                        n_main_tail   = (link_rdata == nla_pkg::NIL_ID) ? nla_pkg::NIL_ID
                                                                        : r_second_tail;
                        n_second_head = nla_pkg::NIL_ID;
                        n_second_tail = nla_pkg::NIL_ID;
                    end
                    nla_pkg::M_SEC_SPLICE: begin
                        // secondary tail now points at the main head
                        link_we       = 1'b1;
                        link_waddr    = r_second_tail[ID_W-1:0];
                        link_wdata    = r_main_head;
                        n_main_head   = (r_cur == r_second_tail) ? r_main_head : link_rdata;
                        n_second_head = nla_pkg::NIL_ID;
                        n_second_tail = nla_pkg::NIL_ID;
                    end
                    default: begin
                        n_main_head = link_rdata;
                        if (link_rdata == nla_pkg::NIL_ID) begin
                            n_main_tail = nla_pkg::NIL_ID;
                        end
                    end
                endcase
                n_state = nla_pkg::S_DONE;
            end

            nla_pkg::S_FIXPREV: begin
                // terminate the moved run at its last waiter
                link_we    = 1'b1;
                link_waddr = r_prev[ID_W-1:0];
                link_wdata = nla_pkg::NIL_ID;
                n_state    = nla_pkg::S_DONE;
            end

            nla_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_gv     = r_res_gv;
                    n_out_id     = r_res_id;
                    n_out_status = nla_pkg::ST_OK;
                    n_state      = nla_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = nla_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_first   <= 1'b1;
            r_lock_busy     <= 1'b0;
            r_holder_id     <= '0;
            r_holder_socket <= '0;
            r_is_waiting    <= '0;
            r_main_head     <= nla_pkg::NIL_ID;
            r_main_tail     <= nla_pkg::NIL_ID;
            r_second_head   <= nla_pkg::NIL_ID;
            r_second_tail   <= nla_pkg::NIL_ID;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_local_first <= i_cfg.local_first;
            end
            r_lock_busy     <= n_lock_busy;
            r_holder_id     <= n_holder_id;
            r_holder_socket <= n_holder_socket;
            r_is_waiting    <= n_is_waiting;
            r_main_head     <= n_main_head;
            r_main_tail     <= n_main_tail;
            r_second_head   <= n_second_head;
            r_second_tail   <= n_second_tail;
            r_out_valid     <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_req        <= n_req;
        r_res_gv     <= n_res_gv;
        r_res_id     <= n_res_id;
        r_out_gv     <= n_out_gv;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    // a free lock has no waiters
    a_free_no_waiters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lock_busy |-> (r_is_waiting == '0))
        else $error("lock free while requesters wait");

    // the holder is never also queued
    a_holder_not_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock_busy |-> !r_is_waiting[r_holder_id])
        else $error("holder marked as waiting");

    // empty queues at rest mean nobody waits
    a_empty_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nla_pkg::S_IDLE && r_main_head == nla_pkg::NIL_ID
         && r_second_head == nla_pkg::NIL_ID) |-> (r_is_waiting == '0))
        else $error("waiters lost from both queues");

endmodule
